[sv/jhtb_pkg.sv]
// constants, field widths and codes for the jpeg huffman table builder
// no dependencies
`default_nettype none

package jhtb_pkg;

    localparam int MAX_SYMBOLS    = 256;
    localparam int CODE_LENGTHS   = 16;
    localparam int LOOKAHEAD_BITS = 8;
    localparam int LOOK_SIZE      = 1 << LOOKAHEAD_BITS;

    localparam int LEN_IDX_W  = $clog2(CODE_LENGTHS);
    localparam int MAXC_IDX_W = $clog2(CODE_LENGTHS + 1);
    localparam int SYM_ADDR_W = $clog2(MAX_SYMBOLS);
    localparam int POS_W      = $clog2(CODE_LENGTHS + MAX_SYMBOLS + 1);
    localparam int TOTAL_W    = 12;
    localparam int CODE_W     = 18;

    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    localparam logic [20:0] MAXCODE_SENTINEL = 21'h0FFFFF;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_MANY  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

endpackage

`default_nettype wire

[sv/jpeg_huffman_table_builder_core.sv]
// jpeg huffman decode table builder: dht byte loader, canonical code builder, table queries
// depends on jhtb_pkg
// count and symbol bytes are taken while idle; a query registers its table reads, then its
// result; the last byte starts a build, not ready meanwhile, of at most 16 overflow checks,
// 16 length steps, one symbol read and 2^(8-len) lookahead writes per code of length up to 8
// reset (synchronous, active low) clears control, counts and tables; symbol store is not reset
`default_nettype none

module jpeg_huffman_table_builder_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // load_byte[7:0], peek_bits[15:8], code_length_index[20:16], symbol_index[28:21]
    input  wire  [jhtb_pkg::IN_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire  [jhtb_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // status[1:0], look_length[5:2], look_symbol[13:6], max_code[34:14],
    // value_offset[51:35], symbol_out[59:52]
    output logic [jhtb_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import jhtb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_QRY  = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    localparam int LB = LOOKAHEAD_BITS;

    logic [2:0]            r_state;
    logic [7:0]            r_cnt [CODE_LENGTHS];
    logic [POS_W-1:0]      r_pos;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_done;
    logic [LEN_IDX_W-1:0]  r_li;
    logic [CODE_W-1:0]     r_code;
    logic [POS_W-1:0]      r_k;
    logic [7:0]            r_i;
    logic [LB-1:0]         r_e;
    logic [1:0]            r_status;
    logic [20:0]           r_max [CODE_LENGTHS+1];
    logic [16:0]           r_off [CODE_LENGTHS];
    logic [LOOK_SIZE-1:0]  r_lvalid;

    logic [7:0]            r_sym_mem  [MAX_SYMBOLS];
    logic [11:0]           r_look_mem [LOOK_SIZE];
    logic [7:0]            r_sym_rd;
    logic [11:0]           r_look_rd;
    logic                  r_lv_rd;
    logic [4:0]            r_q_lidx;
    logic                  r_q_sym_ok;

    logic                     r_ovalid;
    logic [OUT_TDATA_W-1:0]   r_odata;

    logic [KIND_W-1:0]     w_kind;
    logic [7:0]            w_byte;
    logic [LB-1:0]         w_peek;
    logic [4:0]            w_lidx;
    logic [7:0]            w_sidx;
    logic                  w_acc;
    logic                  w_is_load;
    logic [TOTAL_W-1:0]    w_total_next;
    logic                  w_in_counts;
    logic                  w_last_count;
    logic [POS_W-1:0]      w_sym_pos;
    logic                  w_too_many;
    logic [7:0]            w_n;
    logic [4:0]            w_len;
    logic [CODE_W-1:0]     w_sum;
    logic [CODE_W-1:0]     w_limit;
    logic                  w_ovf;
    logic [CODE_W-1:0]     w_code_adv;
    logic [POS_W-1:0]      w_k_adv;
    logic                  w_last_len;
    logic [3:0]            w_shift;
    logic [LB-1:0]         w_span_last;
    logic [CODE_W-1:0]     w_sym_code;
    logic [LB-1:0]         w_look_addr;
    logic [POS_W-1:0]      w_rd_k;
    logic                  w_clear;
    logic                  w_out_free;
    logic                  w_load;
    logic [MAXC_IDX_W-1:0] w_max_idx;
    logic [16:0]           w_off_q;
    logic [OUT_TDATA_W-1:0] w_result;

    assign w_kind = s_tuser;
    assign w_byte = s_tdata[7:0];
    assign w_peek = LB'(s_tdata[15:8]);
    assign w_lidx = s_tdata[20:16];
    assign w_sidx = s_tdata[28:21];

    assign s_tready = (r_state == S_IDLE);
    assign w_acc    = s_tvalid && s_tready;
    assign w_is_load = w_acc && (w_kind == KIND_LOAD) && !r_done;

    assign w_total_next = r_total + TOTAL_W'(w_byte);
    assign w_in_counts  = (r_pos < POS_W'(CODE_LENGTHS));
    assign w_last_count = (r_pos == POS_W'(CODE_LENGTHS - 1));
    assign w_sym_pos    = r_pos - POS_W'(CODE_LENGTHS);
    assign w_too_many   = w_is_load && w_in_counts && w_last_count
                          && (w_total_next > TOTAL_W'(MAX_SYMBOLS));

    // shared length step: running code and symbol index
    assign w_n        = r_cnt[r_li];
    assign w_len      = 5'(r_li) + 5'd1;
    assign w_sum      = r_code + CODE_W'(w_n);
    assign w_limit    = CODE_W'(1) << w_len;
    assign w_ovf      = (w_sum >= w_limit);
    assign w_code_adv = {w_sum[CODE_W-2:0], 1'b0};
    assign w_k_adv    = r_k + POS_W'(w_n);
    assign w_last_len = (r_li == LEN_IDX_W'(CODE_LENGTHS - 1));

    // lookahead fill addressing
    assign w_shift     = 4'(LB) - 4'(w_len);
    assign w_span_last = (LB'(1) << w_shift) - LB'(1);
    assign w_sym_code  = r_code + CODE_W'(r_i);
    assign w_look_addr = LB'(w_sym_code[LB-1:0] << w_shift) + r_e;
    assign w_rd_k      = r_k + POS_W'(r_i);

    assign w_clear = w_too_many
                     || ((r_state == S_CHK) && (w_ovf || w_last_len));

    assign w_out_free = !r_ovalid || m_tready;
    assign w_load     = ((r_state == S_QRY) || (r_state == S_RES)) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_total  <= '0;
            r_done   <= 1'b0;
            r_li     <= '0;
            r_code   <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_e      <= '0;
            r_status <= STATUS_OK;
            for (int j = 0; j < CODE_LENGTHS; j++) begin
                r_cnt[j] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (w_kind)
                            KIND_START: begin
                                for (int j = 0; j < CODE_LENGTHS; j++) begin
                                    r_cnt[j] <= '0;
                                end
                                r_pos   <= '0;
                                r_total <= '0;
                                r_done  <= 1'b0;
                            end
                            KIND_LOAD: begin
                                if (!r_done) begin
                                    r_pos <= r_pos + POS_W'(1);
                                    if (w_in_counts) begin
                                        r_cnt[r_pos[LEN_IDX_W-1:0]] <= w_byte;
                                        r_total <= w_total_next;
                                        if (w_too_many) begin
                                            r_done   <= 1'b1;
                                            r_status <= STATUS_TOO_MANY;
                                            r_state  <= S_RES;
                                        end else if (w_last_count
                                                     && (w_total_next == '0)) begin
                                            r_done  <= 1'b1;
                                            r_li    <= '0;
                                            r_code  <= '0;
                                            r_state <= S_CHK;
                                        end
                                    end else if ((TOTAL_W'(w_sym_pos) + TOTAL_W'(1))
                                                 >= r_total) begin
                                        r_done  <= 1'b1;
                                        r_li    <= '0;
                                        r_code  <= '0;
                                        r_state <= S_CHK;
                                    end
                                end
                            end
                            KIND_QUERY: begin
                                r_state <= S_QRY;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (w_ovf) begin
                        r_status <= STATUS_OVERFLOW;
                        r_state  <= S_RES;
                    end else if (w_last_len) begin
                        r_li    <= '0;
                        r_code  <= '0;
                        r_k     <= '0;
                        r_state <= S_LEN;
                    end else begin
                        r_code <= w_code_adv;
                        r_li   <= r_li + LEN_IDX_W'(1);
                    end
                end
                S_LEN: begin
                    if ((w_n != '0) && (w_len <= 5'(LB))) begin
                        r_i     <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_code <= w_code_adv;
                        r_k    <= w_k_adv;
                        if (w_last_len) begin
                            r_status <= STATUS_OK;
                            r_state  <= S_RES;
                        end else begin
                            r_li <= r_li + LEN_IDX_W'(1);
                        end
                    end
                end
                S_RD: begin
                    r_e     <= '0;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_e == w_span_last) begin
                        if (r_i == (w_n - 8'd1)) begin
                            r_code <= w_code_adv;
                            r_k    <= w_k_adv;
                            if (w_last_len) begin
                                r_status <= STATUS_OK;
                                r_state  <= S_RES;
                            end else begin
                                r_li    <= r_li + LEN_IDX_W'(1);
                                r_state <= S_LEN;
                            end
                        end else begin
                            r_i     <= r_i + 8'd1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_e <= r_e + LB'(1);
                    end
                end
                S_QRY, S_RES: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // max-code, offset and lookahead valid tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= CODE_LENGTHS; j++) begin
                r_max[j] <= '1;
            end
            for (int j = 0; j < CODE_LENGTHS; j++) begin
                r_off[j] <= '0;
            end
            r_lvalid <= '0;
        end else if (w_clear) begin
            for (int j = 0; j < CODE_LENGTHS; j++) begin
                r_max[j] <= '1;
                r_off[j] <= '0;
            end
            r_max[CODE_LENGTHS] <= MAXCODE_SENTINEL;
            r_lvalid <= '0;
        end else begin
            if ((r_state == S_LEN) && (w_n != '0)) begin
                r_off[r_li] <= 17'(r_k) - 17'(r_code);
                r_max[MAXC_IDX_W'(r_li)] <= 21'(w_sum - CODE_W'(1));
            end
            if (r_state == S_WR) begin
                r_lvalid[w_look_addr] <= 1'b1;
            end
        end
    end

    // symbol store
    always_ff @(posedge i_clk) begin
        if (w_is_load && !w_in_counts && (w_sym_pos < POS_W'(MAX_SYMBOLS))) begin
            r_sym_mem[w_sym_pos[SYM_ADDR_W-1:0]] <= w_byte;
        end
        if (r_state == S_RD) begin
            r_sym_rd <= r_sym_mem[w_rd_k[SYM_ADDR_W-1:0]];
        end else if (w_acc && (w_kind == KIND_QUERY)) begin
            r_sym_rd <= r_sym_mem[SYM_ADDR_W'(w_sidx)];
        end
    end

    // lookahead store, entries qualified by r_lvalid
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_look_mem[w_look_addr] <= {4'(w_len), r_sym_rd};
        end
        if (w_acc && (w_kind == KIND_QUERY)) begin
            r_look_rd  <= r_look_mem[w_peek];
            r_lv_rd    <= r_lvalid[w_peek];
            r_q_lidx   <= w_lidx;
            r_q_sym_ok <= (32'(w_sidx) < MAX_SYMBOLS);
        end
    end

    assign w_max_idx = (r_q_lidx < 5'(CODE_LENGTHS)) ? MAXC_IDX_W'(r_q_lidx)
                                                      : MAXC_IDX_W'(CODE_LENGTHS);
    assign w_off_q   = (r_q_lidx < 5'(CODE_LENGTHS)) ? r_off[r_q_lidx[LEN_IDX_W-1:0]]
                                                      : 17'd0;

    always_comb begin
        w_result = '0;
        if (r_state == S_QRY) begin
            w_result[1:0]   = STATUS_OK;
            w_result[5:2]   = r_lv_rd ? r_look_rd[11:8] : 4'd0;
            w_result[13:6]  = r_lv_rd ? r_look_rd[7:0] : 8'd0;
            w_result[34:14] = r_max[w_max_idx];
            w_result[51:35] = w_off_q;
            w_result[59:52] = r_q_sym_ok ? r_sym_rd : 8'd0;
        end else begin
            w_result[1:0]   = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= w_result;
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

    a_wr_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (w_len <= 5'(LB)))
        else $error("lookahead fill beyond lookahead width");

    a_wr_code_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_i < w_n))
        else $error("lookahead fill past code count of length");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_QRY || $past(r_state) == S_RES))
        else $error("result produced outside query or status state");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(CODE_LENGTHS + MAX_SYMBOLS))
        else $error("load position beyond table body");

    a_build_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> r_done)
        else $error("build started without completed load");

endmodule

`default_nettype wire

[sim/jpeg_huffman_table_builder_core_tb.sv]
// testbench for jpeg_huffman_table_builder_core: dht loads, table builds and table queries,
// checked against a behavioural table builder held in the bench
// depends on jhtb_pkg and jpeg_huffman_table_builder_core
`timescale 1ns / 1ps

module jpeg_huffman_table_builder_core_tb;

    import jhtb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 650;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  look_len;
        logic [7:0]  la_sym;
        logic [20:0] max_code;
        logic [16:0] offset;
        logic [7:0]  sym;
    } huff_reply_t;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]       s_tuser  = '0;
    logic                    m_tready = 1'b0;
    wire                     s_tready;
    wire                     m_tvalid;
    wire  [OUT_TDATA_W-1:0]  m_tdata;

    // bench copy of the builder state
    logic [7:0]  len_counts   [CODE_LENGTHS];
    logic [7:0]  sym_mem      [MAX_SYMBOLS];
    bit          sym_written  [MAX_SYMBOLS];
    logic [20:0] maxc_tab     [CODE_LENGTHS + 1];
    logic [16:0] offs_tab     [CODE_LENGTHS];
    logic [3:0]  look_len_tab [LOOK_SIZE];
    logic [7:0]  la_sym_tab   [LOOK_SIZE];
    int unsigned load_pos;
    int unsigned sym_count;
    bit          table_done;

    huff_reply_t builder_replies [$];
    huff_reply_t head_reply;
    int unsigned stored_slots [$];
    logic [7:0]  plan_counts [CODE_LENGTHS];

    int gap_pct   = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;

    jpeg_huffman_table_builder_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_decode_tables();
        int i;
        for (i = 0; i < CODE_LENGTHS; i++) begin
            maxc_tab[i] = '1;
            offs_tab[i] = '0;
        end
        maxc_tab[CODE_LENGTHS] = MAXCODE_SENTINEL;
        for (i = 0; i < LOOK_SIZE; i++) begin
            look_len_tab[i] = '0;
            la_sym_tab[i]   = '0;
        end
    endfunction

    // canonical code assignment; overflow leaves the tables cleared
    function automatic logic [1:0] build_decode_tables();
        int unsigned code;
        int unsigned k;
        int unsigned n;
        int unsigned span;
        int unsigned base;
        int unsigned at;
        int len;
        int unsigned i;
        int unsigned e;
        code = 0;
        for (len = 1; len <= CODE_LENGTHS; len++) begin
            code += len_counts[len-1];
            if (code >= (32'd1 << len)) begin
                clear_decode_tables();
                return STATUS_OVERFLOW;
            end
            code <<= 1;
        end
        clear_decode_tables();
        code = 0;
        k = 0;
        for (len = 1; len <= CODE_LENGTHS; len++) begin
            n = len_counts[len-1];
            if (n != 0) begin
                offs_tab[len-1] = 17'(int'(k) - int'(code));
                for (i = 0; i < n; i++) begin
                    if (len <= LOOKAHEAD_BITS) begin
                        span = 32'd1 << (LOOKAHEAD_BITS - len);
                        base = code << (LOOKAHEAD_BITS - len);
                        for (e = 0; e < span; e++) begin
                            at = (base + e) & (LOOK_SIZE - 1);
                            look_len_tab[at] = 4'(len);
                            la_sym_tab[at]   = sym_mem[(k + i) % MAX_SYMBOLS];
                        end
                    end
                    code++;
                end
                maxc_tab[len-1] = 21'(code - 1);
                k += n;
            end
            code <<= 1;
        end
        return STATUS_OK;
    endfunction

    function automatic void step_table_model(logic [KIND_W-1:0] kind, logic [7:0] tbl_byte,
                                             logic [7:0] peek, logic [4:0] cli,
                                             logic [7:0] sidx);
        huff_reply_t r;
        int unsigned slot;
        int i;
        r = '0;
        case (kind)
            KIND_START: begin
                for (i = 0; i < CODE_LENGTHS; i++) len_counts[i] = '0;
                load_pos = 0;
                sym_count = 0;
                table_done = 1'b0;
            end
            KIND_LOAD: begin
                if (!table_done) begin
                    if (load_pos < CODE_LENGTHS) begin
                        len_counts[load_pos] = tbl_byte;
                        sym_count += tbl_byte;
                        load_pos++;
                        if (load_pos == CODE_LENGTHS) begin
                            if (sym_count > MAX_SYMBOLS) begin
                                clear_decode_tables();
                                table_done = 1'b1;
                                r.status = STATUS_TOO_MANY;
                                builder_replies.push_back(r);
                            end else if (sym_count == 0) begin
                                table_done = 1'b1;
                                r.status = build_decode_tables();
                                builder_replies.push_back(r);
                            end
                        end
                    end else begin
                        slot = load_pos - CODE_LENGTHS;
                        if (slot < MAX_SYMBOLS) begin
                            sym_mem[slot] = tbl_byte;
                            if (!sym_written[slot]) begin
                                sym_written[slot] = 1'b1;
                                stored_slots.push_back(slot);
                            end
                        end
                        load_pos++;
                        if (slot + 1 >= sym_count) begin
                            table_done = 1'b1;
                            r.status = build_decode_tables();
                            builder_replies.push_back(r);
                        end
                    end
                end
            end
            KIND_QUERY: begin
                r.status   = STATUS_OK;
                r.look_len = look_len_tab[peek];
                r.la_sym   = la_sym_tab[peek];
                r.max_code = maxc_tab[(cli < CODE_LENGTHS) ? cli : CODE_LENGTHS];
                r.offset   = (cli < CODE_LENGTHS) ? offs_tab[cli] : '0;
                r.sym      = sym_mem[sidx];
                builder_replies.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_slot();
        if (stored_slots.size() == 0) return 8'd0;
        return 8'(stored_slots[$urandom_range(0, stored_slots.size() - 1)]);
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] tbl_byte,
                             input logic [7:0] peek, input logic [4:0] cli,
                             input logic [7:0] sidx);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, sidx, cli, peek, tbl_byte};
        do @(posedge i_clk); while (!s_tready);
        if (kind != KIND_IGNORED && !(kind == KIND_LOAD && table_done)) items_sent++;
        step_table_model(kind, tbl_byte, peek, cli, sidx);
    endtask

    task automatic send_start();
        send_item(KIND_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), pick_slot());
    endtask

    task automatic send_load(input logic [7:0] v);
        send_item(KIND_LOAD, v, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                  pick_slot());
    endtask

    task automatic send_random_query();
        send_item(KIND_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), pick_slot());
    endtask

    // random counts that form a complete-or-partial prefix code, at most target symbols
    task automatic plan_valid_counts(input int unsigned target);
        int unsigned code;
        int unsigned rem;
        int unsigned lim;
        int len;
        code = 0;
        rem = target;
        for (len = 1; len <= CODE_LENGTHS; len++) begin
            lim = (32'd1 << len) - 1 - code;
            if (rem < lim) lim = rem;
            if (lim > 255) lim = 255;
            plan_counts[len-1] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, lim)) : 8'd0;
            rem -= plan_counts[len-1];
            code = (code + plan_counts[len-1]) << 1;
        end
    endtask

    task automatic send_table();
        int unsigned total;
        int i;
        total = 0;
        send_start();
        for (i = 0; i < CODE_LENGTHS; i++) begin
            send_load(plan_counts[i]);
            total += plan_counts[i];
        end
        if (total > 0 && total <= MAX_SYMBOLS)
            repeat (total) send_load(8'($urandom_range(0, 255)));
    endtask

    // sender idle until every outstanding result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (builder_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_small_table();
        int i;
        send_start();
        for (i = 0; i < CODE_LENGTHS; i++)
            send_load((i == 0 || i == 1 || i == 8) ? 8'd1 : 8'd0);
        send_load(8'hA5);
        send_load(8'h00);
        send_load(8'hFF);
        send_item(KIND_QUERY, 8'h00, 8'h00, 5'd0,  8'd0);
        send_item(KIND_QUERY, 8'hFF, 8'h80, 5'd1,  8'd1);
        send_item(KIND_QUERY, 8'h00, 8'hC0, 5'd8,  8'd2);
        send_item(KIND_QUERY, 8'hFF, 8'hFF, 5'd15, 8'd0);
        send_item(KIND_QUERY, 8'h00, 8'h7F, 5'd16, 8'd1);
        send_item(KIND_QUERY, 8'hFF, 8'h3C, 5'd31, 8'd2);
    endtask

    // loads after a finished table and kind 3 leave everything unchanged
    task automatic test_ignored_items();
        send_load(8'h12);
        send_load(8'hFF);
        send_item(KIND_IGNORED, 8'h55, 8'hAA, 5'd1, 8'd0);
        send_item(KIND_QUERY, 8'h00, 8'h9F, 5'd1, 8'd2);
    endtask

    task automatic test_full_table();
        int i;
        for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = '0;
        plan_counts[7] = 8'd255;
        plan_counts[8] = 8'd1;
        send_table();
        send_item(KIND_QUERY, 8'h00, 8'h00, 5'd7, 8'd0);
        send_item(KIND_QUERY, 8'h00, 8'hFF, 5'd8, 8'd255);
        send_item(KIND_QUERY, 8'h00, 8'hFE, 5'd16, 8'd128);
        send_random_query();
    endtask

    task automatic test_too_many_symbols();
        int i;
        for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = 8'd17;
        send_table();
        send_item(KIND_QUERY, 8'h00, 8'h10, 5'd7, 8'd255);
        for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = 8'd255;
        send_table();
        send_random_query();
    endtask

    task automatic test_code_overflow();
        int i;
        for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = '0;
        plan_counts[0] = 8'd2;
        send_table();
        send_item(KIND_QUERY, 8'h00, 8'h00, 5'd0, 8'd1);
        for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = '0;
        plan_counts[15] = 8'd1;
        plan_counts[1]  = 8'd4;
        send_table();
        send_random_query();
    endtask

    task automatic test_empty_table();
        int i;
        for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = '0;
        send_table();
        send_item(KIND_QUERY, 8'h00, 8'h5A, 5'd3, 8'd9);
        send_item(KIND_QUERY, 8'h00, 8'hA5, 5'd16, 8'd200);
    endtask

    task automatic test_restart_mid_load();
        repeat (5) send_load(8'($urandom_range(0, 3)));
        send_start();
        repeat (3) send_load(8'd1);
        plan_valid_counts(6);
        send_table();
        send_random_query();
        send_random_query();
    endtask

    task automatic test_random_tables(input int target);
        int goal;
        int pick;
        int unsigned sum;
        int i;
        goal = items_sent + target;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                plan_valid_counts(($urandom_range(0, 9) == 0) ? $urandom_range(25, 256)
                                                               : $urandom_range(1, 20));
                send_table();
                repeat ($urandom_range(2, 8)) send_random_query();
            end else if (pick < 75) begin
                plan_valid_counts($urandom_range(1, 12));
                i = $urandom_range(1, LOOKAHEAD_BITS);
                plan_counts[i-1] = 8'((32'd1 << i) - 1 + plan_counts[i-1]);
                if (plan_counts[i-1] == 0) plan_counts[i-1] = 8'd255;
                send_table();
                repeat ($urandom_range(1, 2)) send_random_query();
            end else if (pick < 82) begin
                sum = 0;
                for (i = 0; i < CODE_LENGTHS; i++) begin
                    plan_counts[i] = 8'($urandom_range(0, 255));
                    sum += plan_counts[i];
                end
                if (sum <= MAX_SYMBOLS) plan_counts[15] = 8'd255;
                send_table();
                send_random_query();
            end else if (pick < 87) begin
                for (i = 0; i < CODE_LENGTHS; i++) plan_counts[i] = '0;
                send_table();
                send_random_query();
            end else if (pick < 94) begin
                send_start();
                repeat ($urandom_range(1, 20)) send_load(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(KIND_IGNORED, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                                  pick_slot());
                    else
                        send_load(8'($urandom_range(0, 255)));
                end
                send_random_query();
            end
        end
    endtask

    function automatic void check_field(string label, logic [20:0] want, logic [20:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (builder_replies.size() == 0) begin
                    $display("%0t ns: result expected none got %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    head_reply = builder_replies.pop_front();
                    check_field("status",       21'(head_reply.status),   21'(m_tdata[1:0]));
                    check_field("look_length",  21'(head_reply.look_len), 21'(m_tdata[5:2]));
                    check_field("look_symbol",  21'(head_reply.la_sym),   21'(m_tdata[13:6]));
                    check_field("max_code",     head_reply.max_code,      m_tdata[34:14]);
                    check_field("value_offset", 21'(head_reply.offset),   21'(m_tdata[51:35]));
                    check_field("symbol_out",   21'(head_reply.sym),      21'(m_tdata[59:52]));
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        ref_state_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_small_table();
        test_ignored_items();
        test_full_table();
        test_too_many_symbols();
        test_code_overflow();
        test_empty_table();
        test_restart_mid_load();
        wait_drained();

        test_random_tables(12);
        wait_drained();
        gap_pct = 72;
        test_random_tables(12);
        wait_drained();
        gap_pct = 0;
        stall_pct = 72;
        test_random_tables(12);
        wait_drained();
        gap_pct = 31;
        stall_pct = 31;
        test_random_tables(12);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && builder_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    function automatic void ref_state_reset();
        int i;
        for (i = 0; i < CODE_LENGTHS; i++) begin
            len_counts[i] = '0;
            offs_tab[i]   = '0;
        end
        for (i = 0; i <= CODE_LENGTHS; i++) maxc_tab[i] = '1;
        for (i = 0; i < MAX_SYMBOLS; i++) begin
            sym_mem[i]     = '0;
            sym_written[i] = 1'b0;
        end
        for (i = 0; i < LOOK_SIZE; i++) begin
            look_len_tab[i] = '0;
            la_sym_tab[i]   = '0;
        end
        load_pos   = 0;
        sym_count  = 0;
        table_done = 1'b0;
    endfunction

endmodule

[filelist.f]
sv/jhtb_pkg.sv
sv/jpeg_huffman_table_builder_core.sv
sim/jpeg_huffman_table_builder_core_tb.sv
